// ===== sv/aqlp_pkg.sv =====
// Package: payload structs, constants and helpers for the pricing block.
package aqlp_pkg;

    localparam int MAX_PRICES = 16;
    localparam int Q_BITS     = 32;
    localparam int IDX_W      = $clog2(MAX_PRICES);
    localparam int QADDR_W    = 1 + 2 * IDX_W;
    localparam int Q_FRAC     = Q_BITS - 8;
    localparam logic [15:0] ONE15 = 16'h8000;
    localparam logic [31:0] EPS_ONE = 32'h8000_0000;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_PLAY = 1'b1;

    localparam logic [2:0] REG_LEVELS = 3'd0;
    localparam logic [2:0] REG_ALPHA  = 3'd1;
    localparam logic [2:0] REG_DISC   = 3'd2;
    localparam logic [2:0] REG_DECAY  = 3'd3;
    localparam logic [2:0] REG_FPREV  = 3'd4;
    localparam logic [2:0] REG_FCUR   = 3'd5;
    localparam logic [2:0] REG_SPREV  = 3'd6;
    localparam logic [2:0] REG_SCUR   = 3'd7;

    typedef struct packed {
        logic        opcode;
        logic [3:0]  table_index;
        logic [15:0] price_value;
        logic [15:0] explore_draw;
        logic [3:0]  random_choice;
    } in_item_t;

    typedef struct packed {
        logic        mover;
        logic [3:0]  chosen_index;
        logic [15:0] chosen_price;
        logic        explored;
        logic [15:0] profit_first;
        logic [15:0] profit_second;
    } out_item_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic clr_wr;      // write zero at clear address
        logic load;        // price table load
        logic start;       // latch item, first-play setup
        logic decay;       // decay epsilon once
        logic prep;        // clamp history, pick roles
        logic scan_rd;     // issue Q read of scan row
        logic scan_acc;    // compare returned data
        logic old_rd;      // read old entry
        logic calc1;       // profits into Q
        logic calc2;       // d * profit
        logic calc3;       // colmax * d2
        logic calc4;       // blend
        logic calc5;       // blend shift, write back
        logic choose;      // action and output
        logic scan_clr;    // reset scan pointer
    } ctl_t;

    typedef struct packed {
        logic scan_last;
        logic clr_last;
    } sts_t;

    function automatic logic [15:0] sat15(input logic [15:0] v);
        return (v > ONE15) ? ONE15 : v;
    endfunction

    function automatic logic [15:0] profit_of(input logic [15:0] own, input logic [15:0] rival);
        logic [31:0] m;
        m = 32'(own) * 32'(ONE15 - own);
        if (own < rival) return 16'(m >> 15);
        if (own == rival) return 16'(m >> 16);
        return 16'd0;
    endfunction

endpackage

// ===== sv/aqlp_ram.sv =====
// Generic single-port RAM with registered read.
module aqlp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== sv/aqlp_ctrl.sv =====
// Controller state machine sequencing clear, load and play.
module aqlp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_op,
    output logic              in_stall,
    input  logic              out_busy,
    input  logic              first_play,
    output logic              out_load,
    input  aqlp_pkg::sts_t    sts,
    output aqlp_pkg::ctl_t    ctl
);
    typedef enum logic [14:0] {
        S_CLEAR  = 15'b000000000000001,
        S_IDLE   = 15'b000000000000010,
        S_DECAY  = 15'b000000000000100,
        S_PREP   = 15'b000000000001000,
        S_SRD    = 15'b000000000010000,
        S_SWAIT  = 15'b000000000100000,
        S_SACC   = 15'b000000001000000,
        S_ORD    = 15'b000000010000000,
        S_OWAIT  = 15'b000000100000000,
        S_C1     = 15'b000001000000000,
        S_C2     = 15'b000010000000000,
        S_C3     = 15'b000100000000000,
        S_C4     = 15'b001000000000000,
        S_C5     = 15'b010000000000000,
        S_OUT    = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] dcnt_reg, dcnt_next;
    logic       pass_reg, pass_next;   // second column scan after the write back

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            dcnt_reg  <= '0;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dcnt_reg  <= dcnt_next;
            pass_reg  <= pass_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);
    assign out_load = (state_reg == S_OUT) && !out_busy;

    always_comb
    begin
        state_next = state_reg;
        dcnt_next  = dcnt_reg;
        pass_next  = pass_reg;
        ctl        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_op == aqlp_pkg::OP_LOAD)
                    begin
                        ctl.load = 1'b1;
                    end
                    else
                    begin
                        ctl.start = 1'b1;
                        dcnt_next = first_play ? 2'd3 : 2'd0;
                        state_next = first_play ? S_DECAY : S_PREP;
                    end
                end
            end
            S_DECAY:
            begin
                ctl.decay = 1'b1;
                dcnt_next = dcnt_reg - 2'd1;
                if (dcnt_reg == 2'd1)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                ctl.prep     = 1'b1;
                ctl.scan_clr = 1'b1;
                pass_next    = 1'b0;
                state_next   = S_SRD;
            end
            S_SRD:
            begin
                ctl.scan_rd = 1'b1;
                state_next  = S_SWAIT;
            end
            S_SWAIT:
            begin
                ctl.scan_rd = 1'b1;
                state_next  = S_SACC;
            end
            S_SACC:
            begin
                ctl.scan_acc = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = pass_reg ? S_OUT : S_ORD;
                end
                else
                begin
                    state_next = S_SRD;
                end
            end
            S_ORD:
            begin
                ctl.old_rd = 1'b1;
                state_next = S_OWAIT;
            end
            S_OWAIT:
            begin
                state_next = S_C1;
            end
            S_C1:
            begin
                ctl.calc1  = 1'b1;
                state_next = S_C2;
            end
            S_C2:
            begin
                ctl.calc2  = 1'b1;
                state_next = S_C3;
            end
            S_C3:
            begin
                ctl.calc3  = 1'b1;
                state_next = S_C4;
            end
            S_C4:
            begin
                ctl.calc4  = 1'b1;
                state_next = S_C5;
            end
            S_C5:
            begin
                ctl.calc5    = 1'b1;
                ctl.scan_clr = 1'b1;
                pass_next    = 1'b1;
                state_next   = S_SRD;
            end
            S_OUT:
            begin
                if (!out_busy)
                begin
                    ctl.choose = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end
endmodule

// ===== sv/aqlp_dp.sv =====
// Datapath: Q store, price table, history, epsilon and the arithmetic.
module aqlp_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  aqlp_pkg::ctl_t       ctl,
    output aqlp_pkg::sts_t       sts,
    input  aqlp_pkg::in_item_t   in_item,
    input  logic [4:0]           levels_cfg,
    input  logic [15:0]          alpha_cfg,
    input  logic [15:0]          disc_cfg,
    input  logic [15:0]          decay_cfg,
    input  logic [15:0]          init_hist,
    output logic                 first_play,
    output aqlp_pkg::out_item_t  result
);
    localparam int IW = aqlp_pkg::IDX_W;
    localparam int AW = aqlp_pkg::QADDR_W;
    localparam int QB = aqlp_pkg::Q_BITS;

    logic [QB-1:0] q_max;
    assign q_max = '1;

    // Q store
    logic          q_we;
    logic [AW-1:0] q_addr;
    logic [QB-1:0] q_wdata, q_rdata;

    aqlp_ram #(.WIDTH(QB), .DEPTH(2 * aqlp_pkg::MAX_PRICES * aqlp_pkg::MAX_PRICES)) u_qram (
        .clk   (clk),
        .we    (q_we),
        .addr  (q_addr),
        .wdata (q_wdata),
        .rdata (q_rdata)
    );

    logic [15:0] ptab_reg [aqlp_pkg::MAX_PRICES];
    logic [AW:0] clr_reg;
    logic        started_reg, turn_reg;
    logic [3:0]  hist_reg [4];
    logic [31:0] eps_reg;
    aqlp_pkg::in_item_t item_reg;
    logic [3:0]  a_reg, b_reg, c_reg, n1_reg;
    logic [15:0] d_reg, d2_reg;
    logic [4:0]  row_reg;
    logic [3:0]  best_reg;
    logic [QB-1:0] bestv_reg, old_reg, ne_reg, pq2_reg;
    logic [QB+16:0] t_reg;
    logic [QB+16:0] term_reg;

    function automatic logic [QB-1:0] to_q(input logic [15:0] v);
        if (aqlp_pkg::Q_FRAC >= 15)
            return QB'({16'd0, v} << (aqlp_pkg::Q_FRAC - 15));
        return QB'(v >> (15 - aqlp_pkg::Q_FRAC));
    endfunction

    function automatic logic [15:0] price_at(input logic [3:0] idx);
        return ptab_reg[idx[IW-1:0]];
    endfunction

    logic [3:0] n1;
    always_comb
    begin
        if (levels_cfg < 5'd2)
            n1 = 4'd1;
        else if (levels_cfg > 5'd16)
            n1 = 4'd15;
        else
            n1 = 4'(levels_cfg - 5'd1);
    end

    logic [3:0] h_cl [4];
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            h_cl[i] = (hist_reg[i] > n1) ? n1 : hist_reg[i];
        end
    end

    logic [AW-1:0] col_addr, old_addr;
    assign col_addr = {turn_reg, row_reg[IW-1:0], c_reg[IW-1:0]};
    assign old_addr = {turn_reg, a_reg[IW-1:0], b_reg[IW-1:0]};

    always_comb
    begin
        q_we    = 1'b0;
        q_wdata = '0;
        q_addr  = old_addr;
        if (ctl.clr_wr)
        begin
            q_we   = 1'b1;
            q_addr = clr_reg[AW-1:0];
        end
        else if (ctl.scan_rd)
        begin
            q_addr = col_addr;
        end
        else if (ctl.calc5)
        begin
            q_we    = 1'b1;
            q_wdata = (t_reg[QB+16:15] > (QB+2)'(q_max)) ? q_max : QB'(t_reg >> 15);
        end
    end

    assign sts.clr_last  = (clr_reg == (AW+1)'((1 << AW) - 1));
    assign sts.scan_last = (row_reg[3:0] == n1_reg);
    assign first_play    = !started_reg;

    // epsilon decay factor
    logic [15:0] keep;
    assign keep = aqlp_pkg::ONE15 - aqlp_pkg::sat15(decay_cfg);
    logic [47:0] eps_prod;
    assign eps_prod = 48'(eps_reg) * 48'(keep);

    logic [15:0] alpha;
    assign alpha = aqlp_pkg::sat15(alpha_cfg);

    // choice
    logic        expl;
    logic [3:0]  choice, hn;
    logic [15:0] pc, ph;
    always_comb
    begin
        expl   = ({item_reg.explore_draw, 15'd0} < {1'b0, eps_reg});
        choice = expl ? ((item_reg.random_choice > n1_reg) ? n1_reg : item_reg.random_choice)
                      : best_reg;
        pc     = price_at(choice);
        hn     = turn_reg ? hist_reg[1] : hist_reg[3];
        ph     = price_at(hn);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= '0;
            started_reg <= 1'b0;
            turn_reg    <= 1'b0;
            eps_reg     <= aqlp_pkg::EPS_ONE;
            for (int i = 0; i < 4; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            if (ctl.clr_wr)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (ctl.start && !started_reg)
            begin
                started_reg <= 1'b1;
                eps_reg     <= aqlp_pkg::EPS_ONE;
                hist_reg[0] <= init_hist[15:12];
                hist_reg[1] <= init_hist[11:8];
                hist_reg[2] <= init_hist[7:4];
                hist_reg[3] <= init_hist[3:0];
            end
            if (ctl.decay || ctl.choose)
            begin
                eps_reg <= 32'(eps_prod >> 15);
            end
            if (ctl.prep)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    hist_reg[i] <= h_cl[i];
                end
            end
            if (ctl.choose)
            begin
                turn_reg <= ~turn_reg;
                if (!turn_reg)
                begin
                    hist_reg[0] <= hist_reg[1];
                    hist_reg[1] <= choice;
                    hist_reg[2] <= hist_reg[3];
                end
                else
                begin
                    hist_reg[2] <= hist_reg[3];
                    hist_reg[3] <= choice;
                    hist_reg[0] <= hist_reg[1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load && (5'(in_item.table_index) < 5'(aqlp_pkg::MAX_PRICES)))
        begin
            ptab_reg[in_item.table_index[IW-1:0]] <= aqlp_pkg::sat15(in_item.price_value);
        end
        if (ctl.start)
        begin
            item_reg <= in_item;
        end
        if (ctl.prep)
        begin
            n1_reg <= n1;
            if (!turn_reg)
            begin
                a_reg <= h_cl[0];
                b_reg <= h_cl[2];
                c_reg <= h_cl[3];
                d_reg <= '0;
            end
            else
            begin
                a_reg <= h_cl[2];
                b_reg <= h_cl[0];
                c_reg <= h_cl[1];
                d_reg <= aqlp_pkg::sat15(disc_cfg);
            end
        end
        if (ctl.scan_clr)
        begin
            row_reg <= '0;
        end
        if (ctl.scan_acc)
        begin
            if (row_reg == '0 || q_rdata > bestv_reg)
            begin
                bestv_reg <= q_rdata;
                best_reg  <= row_reg[3:0];
            end
            row_reg <= row_reg + 5'd1;
        end
        if (ctl.calc1)
        begin
            old_reg <= q_rdata;
            d2_reg  <= 16'((32'(d_reg) * 32'(d_reg)) >> 15);
            ne_reg  <= to_q(aqlp_pkg::profit_of(price_at(a_reg), price_at(b_reg)));
            pq2_reg <= to_q(aqlp_pkg::profit_of(price_at(a_reg), price_at(c_reg)));
        end
        if (ctl.calc2)
        begin
            term_reg <= (QB+17)'((QB+17)'(pq2_reg) * (QB+17)'(d_reg)) >> 15;
        end
        if (ctl.calc3)
        begin
            t_reg    <= (QB+17)'(ne_reg) + term_reg;
            term_reg <= (QB+17)'((QB+17)'(bestv_reg) * (QB+17)'(d2_reg)) >> 15;
        end
        if (ctl.calc4)
        begin
            // saturated new estimate blended with old entry
            t_reg <= (QB+17)'(old_reg) * (QB+17)'(aqlp_pkg::ONE15 - alpha)
                   + (QB+17)'(((t_reg + term_reg) > (QB+17)'(q_max)) ? q_max
                              : QB'(t_reg + term_reg)) * (QB+17)'(alpha);
        end
        if (ctl.choose)
        begin
            result.mover        <= turn_reg;
            result.chosen_index <= choice;
            result.chosen_price <= pc;
            result.explored     <= expl;
            result.profit_first <= turn_reg ? aqlp_pkg::profit_of(ph, pc)
                                            : aqlp_pkg::profit_of(pc, ph);
            result.profit_second <= turn_reg ? aqlp_pkg::profit_of(pc, ph)
                                             : aqlp_pkg::profit_of(ph, pc);
        end
    end
endmodule

// ===== sv/alternating_q_learning_pricing.sv =====
// Top level of the alternating duopoly Q-learning pricing block.
//
//   channel   direction  handshake            payload
//   in        input      in_valid/in_stall    in_item_t
//   out       output     out_valid/out_stall  out_item_t
//   cfg       input      APB write/read       registers 0..7 at 4*i
//
// After reset a clearing pass zeroes the 512-entry Q store, one entry a
// cycle; no transaction is accepted meanwhile.
// A load is taken in the idle state without stalling the input. A play
// keeps the input stalled after acceptance: epsilon decay steps on the first play, then
// two column scans of n rows for n levels over the Q RAM port around the Q update.
// The result sits in an output register; a stalled output holds the next
// play in its last state until the register frees.
module alternating_q_learning_pricing (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  aqlp_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output aqlp_pkg::out_item_t out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    logic [4:0]  levels_reg;
    logic [15:0] alpha_reg, disc_reg, decay_reg;
    logic [3:0]  fprev_reg, fcur_reg, sprev_reg, scur_reg;
    logic        valid_reg;
    logic        first_play, out_load;
    aqlp_pkg::ctl_t ctl;
    aqlp_pkg::sts_t sts;
    aqlp_pkg::out_item_t result;

    assign pready = 1'b1;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= 5'd2;
            alpha_reg  <= 16'd16384;
            disc_reg   <= 16'd31130;
            decay_reg  <= '0;
            fprev_reg  <= '0;
            fcur_reg   <= '0;
            sprev_reg  <= '0;
            scur_reg   <= '0;
        end
        else if (psel && penable && pwrite && (paddr[1:0] == 2'b00))
        begin
            unique case (paddr[4:2])
                aqlp_pkg::REG_LEVELS: levels_reg <= pwdata[4:0];
                aqlp_pkg::REG_ALPHA:  alpha_reg  <= pwdata[15:0];
                aqlp_pkg::REG_DISC:   disc_reg   <= pwdata[15:0];
                aqlp_pkg::REG_DECAY:  decay_reg  <= pwdata[15:0];
                aqlp_pkg::REG_FPREV:  fprev_reg  <= pwdata[3:0];
                aqlp_pkg::REG_FCUR:   fcur_reg   <= pwdata[3:0];
                aqlp_pkg::REG_SPREV:  sprev_reg  <= pwdata[3:0];
                aqlp_pkg::REG_SCUR:   scur_reg   <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        prdata = '0;
        unique case (paddr[4:2])
            aqlp_pkg::REG_LEVELS: prdata = 32'(levels_reg);
            aqlp_pkg::REG_ALPHA:  prdata = 32'(alpha_reg);
            aqlp_pkg::REG_DISC:   prdata = 32'(disc_reg);
            aqlp_pkg::REG_DECAY:  prdata = 32'(decay_reg);
            aqlp_pkg::REG_FPREV:  prdata = 32'(fprev_reg);
            aqlp_pkg::REG_FCUR:   prdata = 32'(fcur_reg);
            aqlp_pkg::REG_SPREV:  prdata = 32'(sprev_reg);
            aqlp_pkg::REG_SCUR:   prdata = 32'(scur_reg);
            default:              prdata = '0;
        endcase
    end

    // Output register: filled by the choose step, freed on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = result;

    aqlp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_op      (in_data.opcode),
        .in_stall   (in_stall),
        .out_busy   (valid_reg && out_stall),
        .first_play (first_play),
        .out_load   (out_load),
        .sts        (sts),
        .ctl        (ctl)
    );

    aqlp_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sts        (sts),
        .in_item    (in_data),
        .levels_cfg (levels_reg),
        .alpha_cfg  (alpha_reg),
        .disc_cfg   (disc_reg),
        .decay_cfg  (decay_reg),
        .init_hist  ({fprev_reg, fcur_reg, sprev_reg, scur_reg}),
        .first_play (first_play),
        .result     (result)
    );
endmodule
